/* src/fqse_pkg.sv */
// Shared types, codes and helpers for the searchable FIFO queue.
`default_nettype none
package fqse_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Operation codes carried in the kind field.
  localparam logic [2:0] KIND_ENQ      = 3'd0;
  localparam logic [2:0] KIND_DEQ      = 3'd1;
  localparam logic [2:0] KIND_PEEK     = 3'd2;
  localparam logic [2:0] KIND_EDIT     = 3'd3;
  localparam logic [2:0] KIND_REMOVE   = 3'd4;
  localparam logic [2:0] KIND_DEDUP    = 3'd5;
  localparam logic [2:0] KIND_RM_EVEN  = 3'd6;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic signed [31:0] new_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
    logic [4:0]         count;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_RD,
    S_CMP,
    S_DRD,
    S_DCMP,
    S_FIN
  } state_t;

  // Ring slot at a position from the base index; pos may reach DEPTH.
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(pos);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* src/fifo_queue_with_search_edit.sv */
// Top level of the bounded FIFO queue with search, edit and compaction.
//
// Usage: each input word on in_data carries one operation (enqueue, dequeue,
// peek, edit first match, remove first match, remove duplicates, remove even)
// and produces exactly one result word on out_data: data, status and the
// entry count after the operation. A word moves when valid is high and stall
// is low; the block raises in_stall while an operation is in flight.
// Storage is one synchronous memory of DEPTH words with a single port pair and
// registered read data; every walk goes through it one entry at a time.
// Edit stops at its first match; remove first and remove even walk every
// entry; remove duplicates also reads the kept prefix for each later entry
// until it finds a copy. Each step of a walk issues a read in S_RD or S_DRD
// and uses the data in S_CMP or S_DCMP.
// The result sits in an output register: a stalled receiver holds it there,
// the next input word is still accepted, and its result waits until the
// register frees. Reset clears head, tail, count and all handshake state;
// memory contents are never cleared, only held entries are read.
`default_nettype none
module fifo_queue_with_search_edit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fqse_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fqse_pkg::out_word_t     out_data
);

  localparam int AW = fqse_pkg::ADDR_W;
  localparam int CW = fqse_pkg::CNT_W;

  // Storage: written and read in clocked blocks, registered read data.
  logic signed [31:0] mem [fqse_pkg::DEPTH];
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_wdata;
  logic signed [31:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Control and operation registers.
  fqse_pkg::state_t   state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      occ_r, occ_nxt;
  logic [CW-1:0]      i_r, i_nxt;     // read position of the walk
  logic [CW-1:0]      n_r, n_nxt;     // kept entries so far
  logic [CW-1:0]      j_r, j_nxt;     // inner position for duplicate search
  logic               hit_r, hit_nxt;
  logic [2:0]         kind_r, kind_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic signed [31:0] nval_r, nval_nxt;
  logic signed [31:0] cand_r, cand_nxt;
  logic signed [31:0] data_r, data_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  fqse_pkg::out_word_t out_data_r, out_data_nxt;

  logic               in_acc;
  logic [CW-1:0]      i_inc;
  logic               walk_last;
  logic [CW-1:0]      n_inc;
  logic               match_rem;
  logic               hit_now;
  logic [CW-1:0]      n_rem;

  assign in_stall  = (state_r != fqse_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign i_inc     = i_r + CW'(1);
  assign walk_last = (i_inc == occ_r);
  assign n_inc     = n_r + CW'(1);
  assign match_rem = !hit_r && (mem_rdata == val_r);
  assign hit_now   = hit_r || match_rem;
  assign n_rem     = match_rem ? n_r : n_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fqse_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and walk registers need no reset.
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    n_r        <= n_nxt;
    j_r        <= j_nxt;
    hit_r      <= hit_nxt;
    kind_r     <= kind_nxt;
    val_r      <= val_nxt;
    nval_r     <= nval_nxt;
    cand_r     <= cand_nxt;
    data_r     <= data_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    hit_nxt       = hit_r;
    kind_nxt      = kind_r;
    val_nxt       = val_r;
    nval_nxt      = nval_r;
    cand_nxt      = cand_r;
    data_nxt      = data_r;
    status_nxt    = status_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = fqse_pkg::slot_of(head_r, n_r);
    mem_raddr     = fqse_pkg::slot_of(head_r, i_r);
    mem_wdata     = mem_rdata;

    case (state_r)
      fqse_pkg::S_IDLE: begin
        if (in_acc) begin
          kind_nxt   = in_data.kind;
          val_nxt    = in_data.value;
          nval_nxt   = in_data.new_value;
          data_nxt   = '0;
          status_nxt = fqse_pkg::ST_OK;
          i_nxt      = '0;
          n_nxt      = '0;
          j_nxt      = '0;
          hit_nxt    = 1'b0;
          state_nxt  = fqse_pkg::S_FIN;
          case (in_data.kind)
            fqse_pkg::KIND_ENQ: begin
              if (occ_r == CW'(fqse_pkg::DEPTH)) begin
                status_nxt = fqse_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_r;
                mem_wdata = in_data.value;
                tail_nxt  = fqse_pkg::slot_of(tail_r, CW'(1));
                occ_nxt   = occ_r + CW'(1);
              end
            end
            fqse_pkg::KIND_DEQ, fqse_pkg::KIND_PEEK: begin
              if (occ_r == '0) begin
                status_nxt = fqse_pkg::ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                state_nxt = fqse_pkg::S_HEAD;
              end
            end
            fqse_pkg::KIND_EDIT, fqse_pkg::KIND_REMOVE: begin
              // Default to no match; the walk clears it on a hit.
              status_nxt = fqse_pkg::ST_NOT_FOUND;
              if (occ_r != '0) begin
                state_nxt = fqse_pkg::S_RD;
              end
            end
            fqse_pkg::KIND_DEDUP, fqse_pkg::KIND_RM_EVEN: begin
              if (occ_r != '0) begin
                state_nxt = fqse_pkg::S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      fqse_pkg::S_HEAD: begin
        data_nxt = mem_rdata;
        if (kind_r == fqse_pkg::KIND_DEQ) begin
          head_nxt = fqse_pkg::slot_of(head_r, CW'(1));
          occ_nxt  = occ_r - CW'(1);
        end
        state_nxt = fqse_pkg::S_FIN;
      end

      fqse_pkg::S_RD: begin
        mem_re    = 1'b1;
        state_nxt = fqse_pkg::S_CMP;
      end

      fqse_pkg::S_CMP: begin
        i_nxt     = i_inc;
        state_nxt = walk_last ? fqse_pkg::S_FIN : fqse_pkg::S_RD;
        case (kind_r)
          fqse_pkg::KIND_EDIT: begin
            if (mem_rdata == val_r) begin
              mem_we     = 1'b1;
              mem_waddr  = fqse_pkg::slot_of(head_r, i_r);
              mem_wdata  = nval_r;
              status_nxt = fqse_pkg::ST_OK;
              state_nxt  = fqse_pkg::S_FIN;
            end
          end
          fqse_pkg::KIND_REMOVE: begin
            // Skip the first match, shift the rest down behind it.
            hit_nxt = hit_now;
            n_nxt   = n_rem;
            if (!match_rem) begin
              mem_we = 1'b1;
            end
            if (walk_last && hit_now) begin
              status_nxt = fqse_pkg::ST_OK;
              occ_nxt    = n_rem;
              tail_nxt   = fqse_pkg::slot_of(head_r, n_rem);
            end
          end
          fqse_pkg::KIND_RM_EVEN: begin
            if (mem_rdata[0]) begin
              mem_we = 1'b1;
              n_nxt  = n_inc;
            end
            if (walk_last) begin
              occ_nxt  = mem_rdata[0] ? n_inc : n_r;
              tail_nxt = fqse_pkg::slot_of(head_r, mem_rdata[0] ? n_inc : n_r);
            end
          end
          default: begin
            // Remove duplicates: the first entry is always kept, later ones
            // are checked against the kept prefix.
            cand_nxt = mem_rdata;
            if (n_r == '0) begin
              mem_we = 1'b1;
              n_nxt  = n_inc;
              if (walk_last) begin
                occ_nxt  = n_inc;
                tail_nxt = fqse_pkg::slot_of(head_r, n_inc);
              end
            end else begin
              i_nxt     = i_r;
              j_nxt     = '0;
              state_nxt = fqse_pkg::S_DRD;
            end
          end
        endcase
      end

      fqse_pkg::S_DRD: begin
        mem_re    = 1'b1;
        mem_raddr = fqse_pkg::slot_of(head_r, j_r);
        state_nxt = fqse_pkg::S_DCMP;
      end

      fqse_pkg::S_DCMP: begin
        if (mem_rdata == cand_r) begin
          // Drop the candidate and advance.
          i_nxt     = i_inc;
          state_nxt = walk_last ? fqse_pkg::S_FIN : fqse_pkg::S_RD;
          if (walk_last) begin
            occ_nxt  = n_r;
            tail_nxt = fqse_pkg::slot_of(head_r, n_r);
          end
        end else if ((j_r + CW'(1)) == n_r) begin
          // No earlier copy: keep it at the end of the prefix.
          mem_we    = 1'b1;
          mem_wdata = cand_r;
          n_nxt     = n_inc;
          i_nxt     = i_inc;
          state_nxt = walk_last ? fqse_pkg::S_FIN : fqse_pkg::S_RD;
          if (walk_last) begin
            occ_nxt  = n_inc;
            tail_nxt = fqse_pkg::slot_of(head_r, n_inc);
          end
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = fqse_pkg::S_DRD;
        end
      end

      fqse_pkg::S_FIN: begin
        // Hold until the output register is free or being emptied.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.data_out = data_r;
          out_data_nxt.status   = status_r;
          out_data_nxt.count    = 5'(occ_r);
          state_nxt             = fqse_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = fqse_pkg::S_IDLE;
      end
    endcase
  end

  // Count never exceeds the ring depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(fqse_pkg::DEPTH))
    else $error("occupancy above depth");

  // Between operations the tail sits count entries past the head.
  a_tail_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fqse_pkg::S_IDLE) |-> (tail_r == fqse_pkg::slot_of(head_r, occ_r)))
    else $error("tail out of step with head and count");

  // An enqueue into a queue with room adds exactly one entry.
  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.kind == fqse_pkg::KIND_ENQ) && (occ_r < CW'(fqse_pkg::DEPTH)))
    |=> (occ_r == $past(occ_r) + CW'(1)))
    else $error("enqueue did not add one entry");

  // A result is only loaded from the finishing state.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == fqse_pkg::S_FIN))
    else $error("result loaded outside finishing state");

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the searchable FIFO queue, scored against a queue model.
module testbench;

  // The kind field has one spare code; the block treats it as a no-op.
  localparam logic [2:0] KIND_NOP = 3'd7;

  // Watchdog limit. The longest walk is remove duplicates on a full queue,
  // and this limit is many times the slowest run.
  localparam int CYCLE_LIMIT  = 2000000;
  // Quiet time after the last result, longer than the longest walk.
  localparam int DRAIN_CYCLES = 400;
  // Random words per idling phase. There are four phases.
  localparam int PHASE_WORDS  = 288;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  fqse_pkg::in_word_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  fqse_pkg::out_word_t out_data;

  fifo_queue_with_search_edit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  fqse_pkg::in_word_t  pending_words[$];    // words waiting for the driver
  fqse_pkg::out_word_t expected_results[$]; // results owed by the block, oldest first
  logic signed [31:0]  held_words[$];       // model of the queue contents, head first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int cycle_count    = 0;

  // Small set of words reused so that searches hit and duplicates form.
  logic signed [31:0] word_pool[8];

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one operation to the queue model and return the result it owes.
  function automatic fqse_pkg::out_word_t apply_queue_op(input fqse_pkg::in_word_t w);
    fqse_pkg::out_word_t r;
    logic signed [31:0]  kept[$];
    int                  hit;
    bit                  dup;
    r.data_out = '0;
    r.status   = fqse_pkg::ST_OK;
    hit        = -1;
    case (w.kind)
      fqse_pkg::KIND_ENQ: begin
        // Refuse the word when full; the queue stays as it is.
        if (held_words.size() >= fqse_pkg::DEPTH) begin
          r.status = fqse_pkg::ST_FULL;
        end else begin
          held_words.push_back(w.value);
        end
      end
      fqse_pkg::KIND_DEQ, fqse_pkg::KIND_PEEK: begin
        if (held_words.size() == 0) begin
          r.status = fqse_pkg::ST_EMPTY;
        end else begin
          r.data_out = held_words[0];
          if (w.kind == fqse_pkg::KIND_DEQ) begin
            void'(held_words.pop_front());
          end
        end
      end
      fqse_pkg::KIND_EDIT, fqse_pkg::KIND_REMOVE: begin
        // Only the first match from the head counts.
        foreach (held_words[i]) begin
          if (hit < 0 && held_words[i] == w.value) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          r.status = fqse_pkg::ST_NOT_FOUND;
        end else if (w.kind == fqse_pkg::KIND_EDIT) begin
          held_words[hit] = w.new_value;
        end else begin
          held_words.delete(hit);
        end
      end
      fqse_pkg::KIND_DEDUP: begin
        // Keep the first occurrence of each value, in order.
        foreach (held_words[i]) begin
          dup = 1'b0;
          foreach (kept[j]) begin
            if (kept[j] == held_words[i]) begin
              dup = 1'b1;
            end
          end
          if (!dup) begin
            kept.push_back(held_words[i]);
          end
        end
        held_words = kept;
      end
      fqse_pkg::KIND_RM_EVEN: begin
        // Even means bit zero clear, negative words included.
        foreach (held_words[i]) begin
          if (held_words[i][0]) begin
            kept.push_back(held_words[i]);
          end
        end
        held_words = kept;
      end
      default: begin
        // Spare code: no change, plain ok result.
      end
    endcase
    r.count = 5'(held_words.size());
    return r;
  endfunction

  function automatic void queue_word(input logic [2:0] kind,
                                     input logic signed [31:0] value,
                                     input logic signed [31:0] new_value);
    fqse_pkg::in_word_t w;
    w.kind      = kind;
    w.value     = value;
    w.new_value = new_value;
    pending_words.push_back(w);
  endfunction

  // Mostly pool words, sometimes a fully random one so every bit toggles.
  function automatic logic signed [31:0] pick_word();
    if ($urandom_range(99) < 80) begin
      return word_pool[$urandom_range(7)];
    end
    return $urandom;
  endfunction

  // Pick an operation. A fill bias pushes the queue toward full, a drain
  // bias toward empty, so both ends see traffic.
  function automatic logic [2:0] pick_kind(input bit fill_bias);
    int r;
    r = $urandom_range(99);
    if (r < (fill_bias ? 50 : 22)) begin
      return fqse_pkg::KIND_ENQ;
    end
    if (r < 58) begin
      return fqse_pkg::KIND_DEQ;
    end
    if (r < 66) begin
      return fqse_pkg::KIND_PEEK;
    end
    if (r < 77) begin
      return fqse_pkg::KIND_EDIT;
    end
    if (r < 88) begin
      return fqse_pkg::KIND_REMOVE;
    end
    if (r < 93) begin
      return fqse_pkg::KIND_DEDUP;
    end
    if (r < 98) begin
      return fqse_pkg::KIND_RM_EVEN;
    end
    return KIND_NOP;
  endfunction

  // Score one result word against the oldest owed result.
  task automatic check_result(input fqse_pkg::out_word_t got);
    fqse_pkg::out_word_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result word data_out %0d status %0d count %0d",
               $time, got.data_out, got.status, got.count);
      errors++;
    end else begin
      want = expected_results.pop_front();
      if (got.data_out !== want.data_out) begin
        $display("%0t: data_out expected %0d, got %0d", $time, want.data_out, got.data_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count expected %0d, got %0d", $time, want.count, got.count);
        errors++;
      end
    end
  endtask

  // Driver: score the word accepted at this edge, hold a stalled word,
  // otherwise present the next pending word or leave in_valid low.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_queue_op(in_data));
      end
      if (!(in_valid && in_stall)) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take the result word that moves at this edge, then pick the
  // stall for the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      // Phases: no idling, idle sender, stalling receiver, light idling on both.
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase

      // Refresh the pool: a few small words around zero, the rest wide.
      foreach (word_pool[i]) begin
        word_pool[i] = (i < 3) ? $signed(32'($urandom_range(15))) - 8 : $signed($urandom);
      end

      // Fill away from the edge the driver works on.
      @(negedge clk);

      if (phase == 0) begin
        // Every operation on an empty queue, plus the spare code.
        queue_word(fqse_pkg::KIND_PEEK,    0, 0);
        queue_word(fqse_pkg::KIND_DEQ,     0, 0);
        queue_word(fqse_pkg::KIND_EDIT,    1, 2);
        queue_word(fqse_pkg::KIND_REMOVE,  1, 0);
        queue_word(fqse_pkg::KIND_DEDUP,   0, 0);
        queue_word(fqse_pkg::KIND_RM_EVEN, 0, 0);
        queue_word(KIND_NOP,               -1, -1);
        // Fill to capacity with extremes, negative odd and even words and
        // duplicates, then push one more to hit the full case.
        queue_word(fqse_pkg::KIND_ENQ, 32'sh80000000, 0);
        queue_word(fqse_pkg::KIND_ENQ, 32'sh7fffffff, 0);
        queue_word(fqse_pkg::KIND_ENQ, 0, 0);
        queue_word(fqse_pkg::KIND_ENQ, -1, 0);
        queue_word(fqse_pkg::KIND_ENQ, -2, 0);
        for (int i = 0; i < 11; i++) begin
          queue_word(fqse_pkg::KIND_ENQ, (i % 3) - 1, 0);
        end
        queue_word(fqse_pkg::KIND_ENQ, 7, 0);
        // Edit a hit on a full queue, miss a remove, then compact.
        queue_word(fqse_pkg::KIND_EDIT,    -1, 32'sh7fffffff);
        queue_word(fqse_pkg::KIND_REMOVE,  12345, 0);
        queue_word(fqse_pkg::KIND_DEDUP,   0, 0);
        queue_word(fqse_pkg::KIND_RM_EVEN, 0, 0);
        queue_word(fqse_pkg::KIND_DEQ,     0, 0);
      end

      // Random part; flip the bias every 40 words.
      for (int n = 0; n < PHASE_WORDS; n++) begin
        queue_word(pick_kind(((n / 40) % 2) == 0), pick_word(), pick_word());
      end

      // Let the driver drain this phase before changing the idling.
      while (pending_words.size() != 0 || in_valid) begin
        @(posedge clk);
      end
    end

    recv_stall_pct = 0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    // Watch for stray result words after the last one owed.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
